// File: rtl/kmtr_pkg.sv
`timescale 1ns / 1ps
// kmtr_pkg: opcodes and memory word layouts for the killer move table
// no dependencies

package kmtr_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_SAVE    = 2'd1,
    OP_LOAD    = 2'd2,
    OP_REORDER = 2'd3
  } op_e;

  localparam int unsigned MoveW  = 32;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned LenW   = 7;
  localparam int unsigned EmitCap = 64;

  typedef struct packed {
    logic [MoveW-1:0] second;
    logic [MoveW-1:0] first;
  } killer_t;

  typedef struct packed {
    logic [MoveW-1:0] mv;
    logic [MoveW-1:0] sc;
  } entry_t;

endpackage

// File: rtl/killer_move_table_reorder_top.sv
`timescale 1ns / 1ps
// killer_move_table_reorder_top: two-slot killer table per depth and a move list
// that is reordered around the killers and then streamed out
// depends on kmtr_pkg
// clear and load act on the transfer; save reads the pair, shifts in a new first killer
// reorder: killer read after the transfer, then two passes (first killer from the start
// position, second from one past it); a hit rotates the entries from start to hit up by
// one and puts the hit at the start; then the list is emitted from index zero, each
// result in the cycle after its emit read; no stall
// reset clears the killer valid bits at once (killers read as zero), list is undefined

module killer_move_table_reorder_top
  import kmtr_pkg::*;
#(
  parameter int unsigned MAX_SEARCH_DEPTH = 64,
  parameter int unsigned LIST_SIZE        = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              opcode_i,
  input  logic [IdxW-1:0]         depth_i,
  input  logic signed [MoveW-1:0] move_value_i,
  input  logic signed [MoveW-1:0] score_value_i,
  input  logic [IdxW-1:0]         position_i,
  input  logic [IdxW-1:0]         start_position_i,
  input  logic [LenW-1:0]         list_length_i,
  output logic                    out_valid_o,
  output logic signed [MoveW-1:0] out_move_o,
  output logic signed [MoveW-1:0] out_score_o,
  output logic [IdxW-1:0]         out_index_o,
  output logic                    last_o
);

  localparam int unsigned DAW = $clog2(MAX_SEARCH_DEPTH);
  localparam int unsigned LAW = $clog2(LIST_SIZE);
  localparam int unsigned CAP = (LIST_SIZE < EmitCap) ? LIST_SIZE : EmitCap;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAVE,
    ST_KEY,
    ST_SEARCH,
    ST_ROTATE,
    ST_EMIT
  } state_e;

  state_e                state_q, state_d;
  logic [MAX_SEARCH_DEPTH-1:0] kval_q, kval_d;
  logic [DAW-1:0]        sd_q, sd_d;
  logic [MoveW-1:0]      smv_q, smv_d;
  logic [MoveW-1:0]      key_q, key_d;
  logic [MoveW-1:0]      k2_q, k2_d;
  logic [LenW-1:0]       from_q, from_d;
  logic [LenW-1:0]       ptr_q, ptr_d;
  logic [LenW-1:0]       len_q, len_d;
  logic [LenW-1:0]       ridx_q, ridx_d;
  logic [LenW-1:0]       widx_q, widx_d;
  logic                  rv_q, rv_d;
  logic                  wv_q, wv_d;
  logic                  pass_q, pass_d;
  entry_t                hold_q, hold_d;
  logic                  strobe_q, strobe_d;
  logic [IdxW-1:0]       oidx_q, oidx_d;
  logic                  last_q, last_d;

  // killer memory
  killer_t               kmem [MAX_SEARCH_DEPTH];
  killer_t               kr_q;
  logic                  kvr_q;
  logic                  krd_en;
  logic                  kwr_en;
  logic [DAW-1:0]        kwr_addr;
  killer_t               kwr_data;

  // list memory
  entry_t                lmem [LIST_SIZE];
  entry_t                lrd_q;
  logic                  lrd_en;
  logic [LAW-1:0]        lrd_addr;
  logic                  lwr_en;
  logic [LAW-1:0]        lwr_addr;
  entry_t                lwr_data;

  logic [DAW-1:0]        depth_lut [64];
  logic [DAW-1:0]        depth_mod;
  logic [LenW-1:0]       len_sat;
  logic                  accept;
  logic [MoveW-1:0]      kfirst;
  logic [MoveW-1:0]      ksecond;
  logic                  pass_done;

  for (genvar g = 0; g < 64; g++) begin : g_depth_lut
    assign depth_lut[g] = DAW'(g % MAX_SEARCH_DEPTH);
  end

  assign depth_mod = depth_lut[depth_i];
  assign len_sat   = (list_length_i > LenW'(CAP)) ? LenW'(CAP) : list_length_i;
  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign kfirst    = kvr_q ? kr_q.first  : '0;
  assign ksecond   = kvr_q ? kr_q.second : '0;

  always_ff @(posedge clk_i) begin
    if (krd_en) begin
      kr_q  <= kmem[depth_mod];
      kvr_q <= kval_q[depth_mod];
    end
    if (kwr_en) begin
      kmem[kwr_addr] <= kwr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lrd_en) begin
      lrd_q <= lmem[lrd_addr];
    end
    if (lwr_en) begin
      lmem[lwr_addr] <= lwr_data;
    end
  end

  always_comb begin
    state_d  = state_q;
    kval_d   = kval_q;
    sd_d     = sd_q;
    smv_d    = smv_q;
    key_d    = key_q;
    k2_d     = k2_q;
    from_d   = from_q;
    ptr_d    = ptr_q;
    len_d    = len_q;
    ridx_d   = ridx_q;
    widx_d   = widx_q;
    rv_d     = rv_q;
    wv_d     = wv_q;
    pass_d   = pass_q;
    hold_d   = hold_q;
    strobe_d = 1'b0;
    oidx_d   = oidx_q;
    last_d   = last_q;
    krd_en   = 1'b0;
    kwr_en   = 1'b0;
    kwr_addr = sd_q;
    kwr_data = '{second: kfirst, first: smv_q};
    lrd_en   = 1'b0;
    lrd_addr = LAW'(ptr_q);
    lwr_en   = 1'b0;
    lwr_addr = LAW'(widx_q);
    lwr_data = lrd_q;
    pass_done = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_e'(opcode_i))
            OP_CLEAR: begin
              kval_d = '0;
            end
            OP_SAVE: begin
              krd_en  = 1'b1;
              sd_d    = depth_mod;
              smv_d   = move_value_i;
              state_d = ST_SAVE;
            end
            OP_LOAD: begin
              if (9'(position_i) < 9'(LIST_SIZE)) begin
                lwr_en   = 1'b1;
                lwr_addr = LAW'(position_i);
                lwr_data = '{mv: move_value_i, sc: score_value_i};
              end
            end
            OP_REORDER: begin
              krd_en  = 1'b1;
              from_d  = LenW'(start_position_i);
              len_d   = len_sat;
              state_d = ST_KEY;
            end
            default: ;
          endcase
        end
      end
      ST_SAVE: begin
        if (kfirst != smv_q) begin
          kwr_en       = 1'b1;
          kval_d[sd_q] = 1'b1;
        end
        state_d = ST_IDLE;
      end
      ST_KEY: begin
        key_d   = kfirst;
        k2_d    = ksecond;
        ptr_d   = from_q;
        rv_d    = 1'b0;
        wv_d    = 1'b0;
        pass_d  = 1'b0;
        state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (rv_q && (lrd_q.mv == key_q)) begin
          hold_d  = lrd_q;
          ptr_d   = ridx_q;
          rv_d    = 1'b0;
          wv_d    = 1'b0;
          state_d = ST_ROTATE;
        end else if (ptr_q < len_q) begin
          lrd_en   = 1'b1;
          lrd_addr = LAW'(ptr_q);
          rv_d     = 1'b1;
          ridx_d   = ptr_q;
          ptr_d    = ptr_q + LenW'(1);
        end else begin
          pass_done = 1'b1;
        end
      end
      ST_ROTATE: begin
        // shift entries up by one toward the hit, then drop the hit at the front
        if (wv_q) begin
          lwr_en   = 1'b1;
          lwr_addr = LAW'(widx_q);
          lwr_data = lrd_q;
        end
        if (ptr_q > from_q) begin
          lrd_en   = 1'b1;
          lrd_addr = LAW'(ptr_q - LenW'(1));
          wv_d     = 1'b1;
          widx_d   = ptr_q;
          ptr_d    = ptr_q - LenW'(1);
        end else if (!wv_q) begin
          lwr_en    = 1'b1;
          lwr_addr  = LAW'(from_q);
          lwr_data  = hold_q;
          pass_done = 1'b1;
        end else begin
          wv_d = 1'b0;
        end
      end
      ST_EMIT: begin
        if (ptr_q < len_q) begin
          lrd_en   = 1'b1;
          lrd_addr = LAW'(ptr_q);
          strobe_d = 1'b1;
          oidx_d   = IdxW'(ptr_q);
          last_d   = ((ptr_q + LenW'(1)) == len_q);
          ptr_d    = ptr_q + LenW'(1);
          if ((ptr_q + LenW'(1)) == len_q) begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (pass_done) begin
      rv_d = 1'b0;
      wv_d = 1'b0;
      if (!pass_q) begin
        pass_d  = 1'b1;
        key_d   = k2_q;
        from_d  = from_q + LenW'(1);
        ptr_d   = from_q + LenW'(1);
        state_d = ST_SEARCH;
      end else begin
        ptr_d   = '0;
        state_d = ST_EMIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      kval_q   <= '0;
      sd_q     <= '0;
      smv_q    <= '0;
      key_q    <= '0;
      k2_q     <= '0;
      from_q   <= '0;
      ptr_q    <= '0;
      len_q    <= '0;
      ridx_q   <= '0;
      widx_q   <= '0;
      rv_q     <= 1'b0;
      wv_q     <= 1'b0;
      pass_q   <= 1'b0;
      hold_q   <= '0;
      strobe_q <= 1'b0;
      oidx_q   <= '0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      kval_q   <= kval_d;
      sd_q     <= sd_d;
      smv_q    <= smv_d;
      key_q    <= key_d;
      k2_q     <= k2_d;
      from_q   <= from_d;
      ptr_q    <= ptr_d;
      len_q    <= len_d;
      ridx_q   <= ridx_d;
      widx_q   <= widx_d;
      rv_q     <= rv_d;
      wv_q     <= wv_d;
      pass_q   <= pass_d;
      hold_q   <= hold_d;
      strobe_q <= strobe_d;
      oidx_q   <= oidx_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o = strobe_q;
  assign out_move_o  = signed'(lrd_q.mv);
  assign out_score_o = signed'(lrd_q.sc);
  assign out_index_o = oidx_q;
  assign last_o      = last_q;

  // result transfers only follow emit reads
  a_strobe_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(state_q == ST_EMIT))
    else $error("result strobe without emit read");

  // the final transfer leaves the block idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (state_q == ST_IDLE))
    else $error("block busy after last transfer");

  // the list is never read and written at the same entry in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lwr_en && lrd_en) |-> (lwr_addr != lrd_addr))
    else $error("list read and write hit the same entry");

  // emitted indexes count up without gaps
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && $past(out_valid_o) && !$past(last_o))
      |-> (out_index_o == IdxW'($past(out_index_o) + IdxW'(1))))
    else $error("emitted index skipped");

  // killer write only in the cycle right after a save transfer
  a_save_writes_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kwr_en |-> ($past(state_q == ST_IDLE) && (state_q == ST_SAVE) && !lwr_en))
    else $error("killer write outside save");

endmodule

// File: tb/killer_move_table_reorder_top_tb.sv
`timescale 1ns / 1ps
// killer_move_table_reorder_top_tb: self-checking bench for the killer move table and
// list reorder; a scoreboard class predicts the emitted list, plain tasks drive commands
// depends on kmtr_pkg and killer_move_table_reorder_top

module killer_move_table_reorder_top_tb
  import kmtr_pkg::*;
();

  localparam int unsigned Depths     = 64;
  localparam int unsigned Slots      = 64;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned DrainWait  = 400;

  typedef struct {
    op_e                     op;
    logic [IdxW-1:0]         depth;
    logic signed [MoveW-1:0] mv;
    logic signed [MoveW-1:0] sc;
    logic [IdxW-1:0]         pos;
    logic [IdxW-1:0]         start_pos;
    logic [LenW-1:0]         len;
  } kmtr_cmd_t;

  typedef struct {
    logic signed [MoveW-1:0] mv;
    logic signed [MoveW-1:0] sc;
    logic [IdxW-1:0]         idx;
    logic                    lst;
  } list_entry_t;

  class killer_table_sb;
    logic [MoveW-1:0] kfirst [Depths];
    logic [MoveW-1:0] ksecond[Depths];
    logic [MoveW-1:0] lmove  [Slots];
    logic [MoveW-1:0] lscore [Slots];
    bit               written[Slots];
    list_entry_t      expected_entries[$];
    int               errors;

    function new();
      foreach (kfirst[i]) begin
        kfirst[i]  = '0;
        ksecond[i] = '0;
      end
      foreach (lmove[i]) begin
        lmove[i]   = '0;
        lscore[i]  = '0;
        written[i] = 1'b0;
      end
      errors = 0;
    endfunction

    // number of entries loaded without a hole from index zero
    function int loaded_prefix();
      int n;
      n = 0;
      while (n < Slots && written[n]) n++;
      return n;
    endfunction

    function void pull_front(logic [MoveW-1:0] key, int from, int len);
      int j;
      logic [MoveW-1:0] m;
      logic [MoveW-1:0] s;
      for (j = from; j < len; j++) begin
        if (lmove[j] == key) break;
      end
      if (j >= len) return;
      m = lmove[j];
      s = lscore[j];
      while (j > from) begin
        lmove[j]  = lmove[j-1];
        lscore[j] = lscore[j-1];
        j--;
      end
      lmove[from]  = m;
      lscore[from] = s;
    endfunction

    function void apply_command(kmtr_cmd_t c);
      int len;
      list_entry_t e;
      case (c.op)
        OP_CLEAR: begin
          foreach (kfirst[i]) begin
            kfirst[i]  = '0;
            ksecond[i] = '0;
          end
        end
        OP_SAVE: begin
          if (kfirst[c.depth] != c.mv) begin
            ksecond[c.depth] = kfirst[c.depth];
            kfirst[c.depth]  = c.mv;
          end
        end
        OP_LOAD: begin
          lmove[c.pos]   = c.mv;
          lscore[c.pos]  = c.sc;
          written[c.pos] = 1'b1;
        end
        default: begin
          len = (c.len > Slots) ? Slots : int'(c.len);
          pull_front(kfirst[c.depth], int'(c.start_pos), len);
          pull_front(ksecond[c.depth], int'(c.start_pos) + 1, len);
          for (int i = 0; i < len; i++) begin
            e.mv  = lmove[i];
            e.sc  = lscore[i];
            e.idx = i[IdxW-1:0];
            e.lst = (i == len - 1);
            expected_entries.push_back(e);
          end
        end
      endcase
    endfunction

    function void check_entry(list_entry_t got);
      list_entry_t want;
      if (expected_entries.size() == 0) begin
        $display("%0t: unexpected entry move %0d score %0d index %0d last %0b",
                 $time, got.mv, got.sc, got.idx, got.lst);
        errors++;
        return;
      end
      want = expected_entries.pop_front();
      if (got.mv !== want.mv) begin
        $display("%0t: out_move expected %0d actual %0d", $time, want.mv, got.mv);
        errors++;
      end
      if (got.sc !== want.sc) begin
        $display("%0t: out_score expected %0d actual %0d", $time, want.sc, got.sc);
        errors++;
      end
      if (got.idx !== want.idx) begin
        $display("%0t: out_index expected %0d actual %0d", $time, want.idx, got.idx);
        errors++;
      end
      if (got.lst !== want.lst) begin
        $display("%0t: last expected %0b actual %0b", $time, want.lst, got.lst);
        errors++;
      end
    endfunction
  endclass

  logic                    clk_i            = 1'b0;
  logic                    rst_ni           = 1'b0;
  logic                    start            = 1'b0;
  logic [1:0]              opcode_i         = '0;
  logic [IdxW-1:0]         depth_i          = '0;
  logic signed [MoveW-1:0] move_value_i     = '0;
  logic signed [MoveW-1:0] score_value_i    = '0;
  logic [IdxW-1:0]         position_i       = '0;
  logic [IdxW-1:0]         start_position_i = '0;
  logic [LenW-1:0]         list_length_i    = '0;
  logic                    busy;
  logic                    out_valid_o;
  logic signed [MoveW-1:0] out_move_o;
  logic signed [MoveW-1:0] out_score_o;
  logic [IdxW-1:0]         out_index_o;
  logic                    last_o;

  killer_table_sb sb;
  int unsigned    cycles     = 0;
  int             items_sent = 0;

  killer_move_table_reorder_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .opcode_i         (opcode_i),
    .depth_i          (depth_i),
    .move_value_i     (move_value_i),
    .score_value_i    (score_value_i),
    .position_i       (position_i),
    .start_position_i (start_position_i),
    .list_length_i    (list_length_i),
    .out_valid_o      (out_valid_o),
    .out_move_o       (out_move_o),
    .out_score_o      (out_score_o),
    .out_index_o      (out_index_o),
    .last_o           (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("killer_move_table_reorder_top_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    list_entry_t got;
    if (rst_ni && out_valid_o) begin
      got.mv  = out_move_o;
      got.sc  = out_score_o;
      got.idx = out_index_o;
      got.lst = last_o;
      sb.check_entry(got);
    end
  end

  function automatic logic [MoveW-1:0] rand_move();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      4, 5:    return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // lengths never reach an entry that was not loaded
  function automatic logic [LenW-1:0] pick_len(int pre);
    if (pre == Slots && $urandom_range(0, 9) == 0) return LenW'($urandom_range(64, 127));
    if ($urandom_range(0, 9) < 6) return LenW'($urandom_range(0, (pre < 12) ? pre : 12));
    return LenW'($urandom_range(0, pre));
  endfunction

  function automatic logic [IdxW-1:0] pick_start(logic [LenW-1:0] len);
    int eff;
    eff = (len > Slots) ? Slots : int'(len);
    if (eff > 0 && $urandom_range(0, 9) < 7) return IdxW'($urandom_range(0, eff - 1));
    return IdxW'($urandom_range(0, 63));
  endfunction

  function automatic kmtr_cmd_t mk(op_e op, int depth, logic [MoveW-1:0] mv,
                                   logic [MoveW-1:0] sc, int pos, int sp, int len);
    kmtr_cmd_t c;
    c.op        = op;
    c.depth     = IdxW'(depth);
    c.mv        = mv;
    c.sc        = sc;
    c.pos       = IdxW'(pos);
    c.start_pos = IdxW'(sp);
    c.len       = LenW'(len);
    return c;
  endfunction

  function automatic kmtr_cmd_t rand_fields(op_e op);
    kmtr_cmd_t c;
    c.op        = op;
    c.depth     = IdxW'($urandom_range(0, 63));
    c.mv        = rand_move();
    c.sc        = $urandom;
    c.pos       = IdxW'($urandom_range(0, 63));
    c.len       = pick_len(sb.loaded_prefix());
    c.start_pos = pick_start(c.len);
    return c;
  endfunction

  task automatic issue(kmtr_cmd_t c, int idle_pct);
    start            <= 1'b1;
    opcode_i         <= c.op;
    depth_i          <= c.depth;
    move_value_i     <= c.mv;
    score_value_i    <= c.sc;
    position_i       <= c.pos;
    start_position_i <= c.start_pos;
    list_length_i    <= c.len;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.apply_command(c);
    items_sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // optional clear, saves at one depth, a short load seeded with its killers, a reorder
  task automatic search_node(int idle_pct);
    kmtr_cmd_t c;
    int d;
    int n;
    int base;
    int r;
    d = $urandom_range(0, 63);
    if ($urandom_range(0, 9) == 0) issue(rand_fields(OP_CLEAR), idle_pct);
    repeat ($urandom_range(0, 2)) begin
      c = rand_fields(OP_SAVE);
      c.depth = IdxW'(d);
      if ($urandom_range(0, 3) == 0) c.mv = sb.kfirst[d];
      issue(c, idle_pct);
    end
    n = $urandom_range(0, 10);
    base = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63 - n) : 0;
    for (int i = 0; i < n; i++) begin
      c = rand_fields(OP_LOAD);
      c.pos = IdxW'(base + i);
      r = $urandom_range(0, 9);
      if (r < 3) c.mv = sb.kfirst[d];
      else if (r < 6) c.mv = sb.ksecond[d];
      issue(c, idle_pct);
    end
    c = rand_fields(OP_REORDER);
    if ($urandom_range(0, 9) != 0) c.depth = IdxW'(d);
    issue(c, idle_pct);
  endtask

  initial begin
    int idle_pct[4];
    int target;
    idle_pct = '{0, 87, 0, 17};
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list before anything is loaded
    issue(mk(OP_REORDER, 0, 0, 0, 0, 0, 0), 0);
    issue(mk(OP_LOAD, 0, 32'h0000_0000, 32'h7fff_ffff, 0, 0, 0), 0);
    issue(mk(OP_LOAD, 0, 32'h7fff_ffff, 32'h8000_0000, 1, 0, 0), 0);
    issue(mk(OP_LOAD, 0, 32'h8000_0000, 32'hffff_ffff, 2, 0, 0), 0);
    issue(mk(OP_LOAD, 0, 32'hffff_ffff, 32'h0000_0000, 3, 0, 0), 0);
    issue(mk(OP_LOAD, 0, 32'd5, 32'd55, 4, 0, 0), 0);
    issue(mk(OP_LOAD, 0, 32'd7, 32'd77, 5, 0, 0), 0);
    issue(mk(OP_LOAD, 0, 32'h1234_5678, 32'h8765_4321, 63, 0, 0), 0);
    issue(mk(OP_SAVE, 63, 32'h8000_0000, 0, 0, 0, 0), 0);
    issue(mk(OP_SAVE, 63, 32'd7, 0, 0, 0, 0), 0);
    // same move again leaves the pair alone
    issue(mk(OP_SAVE, 63, 32'd7, 0, 0, 0, 0), 0);
    issue(mk(OP_REORDER, 63, 0, 0, 0, 0, 6), 0);
    issue(mk(OP_REORDER, 63, 0, 0, 0, 5, 6), 0);
    // start at and beyond the length
    issue(mk(OP_REORDER, 63, 0, 0, 0, 6, 6), 0);
    issue(mk(OP_REORDER, 63, 0, 0, 0, 63, 6), 0);
    issue(mk(OP_REORDER, 0, 0, 0, 0, 0, 6), 0);
    issue(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0), 0);
    issue(mk(OP_REORDER, 63, 0, 0, 0, 2, 6), 0);
    // first killer absent, second still searched
    issue(mk(OP_SAVE, 1, 32'd3, 0, 0, 0, 0), 0);
    issue(mk(OP_REORDER, 1, 0, 0, 0, 0, 6), 0);

    // fill the whole list once so full and saturated lengths become legal
    for (int i = 0; i < Slots; i++) begin
      issue(mk(OP_LOAD, 0, rand_move(), $urandom, i, 0, 0), 0);
    end

    target = items_sent;
    for (int p = 0; p < 4; p++) begin
      target += 55;
      while (items_sent < target) begin
        if ($urandom_range(0, 99) < 15) issue(rand_fields(op_e'($urandom_range(0, 3))),
                                              idle_pct[p]);
        else search_node(idle_pct[p]);
      end
    end
    start <= 1'b0;

    while (sb.expected_entries.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_entries.size() == 0) begin
      $display("killer_move_table_reorder_top_tb: done, clean");
    end else begin
      $display("killer_move_table_reorder_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/kmtr_pkg.sv
rtl/killer_move_table_reorder_top.sv
tb/killer_move_table_reorder_top_tb.sv
